// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, held off while reset is high.
`define NBBR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every rising edge, reset included.
`define NBBR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/nbbr_pkg.sv -----
package nbbr_pkg;

  localparam int CNT_W   = 13;
  localparam int PAGE_W  = 20;
  localparam int BLK_W   = 12;
  localparam int TAG_W   = 16;
  localparam int LOG2_W  = 4;
  localparam int IDX_W   = 2;

  localparam int DEF_MAX_BLOCKS     = 4096;
  localparam int DEF_MAX_PAGES_LOG2 = 8;

  localparam logic [TAG_W-1:0] BLANK_TAG = 16'hFFFF;

  localparam logic [1:0] KIND_SCAN      = 2'd0;
  localparam logic [1:0] KIND_TRANSLATE = 2'd1;
  localparam logic [1:0] KIND_REMAP     = 2'd2;

  localparam logic [1:0] SCAN_GOOD = 2'd0;
  localparam logic [1:0] SCAN_BAD  = 2'd1;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_OUT_OF_RANGE = 3'd1;
  localparam logic [2:0] ST_NO_SPARE     = 3'd2;
  localparam logic [2:0] ST_BAD_TAG      = 3'd3;
  localparam logic [2:0] ST_DUP_TAG      = 3'd4;
  localparam logic [2:0] ST_READ_ERROR   = 3'd5;
  localparam logic [2:0] ST_SCAN_CLOSED  = 3'd6;

  localparam logic [IDX_W-1:0] REG_PAGES_LOG2  = 2'd0;
  localparam logic [IDX_W-1:0] REG_PHYS_COUNT  = 2'd1;
  localparam logic [IDX_W-1:0] REG_LOG_COUNT   = 2'd2;

  localparam logic [LOG2_W-1:0] RST_PAGES_LOG2 = 4'd6;
  localparam logic [CNT_W-1:0]  RST_PHYS_COUNT = 13'd1024;
  localparam logic [CNT_W-1:0]  RST_LOG_COUNT  = 13'd1000;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        scan_status;
    logic [TAG_W-1:0]  scan_tag;
    logic [PAGE_W-1:0] logical_page;
    logic [BLK_W-1:0]  logical_block;
  } request_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [PAGE_W-1:0] physical_page;
    logic [BLK_W-1:0]  physical_block;
    logic              scan_complete;
    logic [CNT_W-1:0]  bad_block_count;
  } result_t;

  typedef struct packed {
    logic [LOG2_W-1:0] pages_log2;
    logic [CNT_W-1:0]  phys_count;
    logic [CNT_W-1:0]  log_count;
  } cfg_t;

  typedef struct packed {
    logic             mapped;
    logic [CNT_W-1:0] block;
  } entry_t;

  typedef struct packed {
    logic     valid;
    request_t req;
  } stage_t;

endpackage

// ----- hdl/nbbr_ram.sv -----
module nbbr_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/nbbr_cfg.sv -----
module nbbr_cfg #(
  parameter int MAX_BLOCKS     = nbbr_pkg::DEF_MAX_BLOCKS,
  parameter int MAX_PAGES_LOG2 = nbbr_pkg::DEF_MAX_PAGES_LOG2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [nbbr_pkg::IDX_W-1:0]    cfg_index,
  input  logic [nbbr_pkg::CNT_W-1:0]    cfg_data,
  output nbbr_pkg::cfg_t                cfg
);

  localparam int CW      = nbbr_pkg::CNT_W;
  localparam int LW      = nbbr_pkg::LOG2_W;
  localparam int CNT_CAP = (MAX_BLOCKS > 8191) ? 8191 : MAX_BLOCKS;
  localparam logic [CW-1:0] CAP      = CW'(CNT_CAP);
  localparam logic [LW-1:0] LOG2_CAP = LW'(MAX_PAGES_LOG2);

  logic [LW-1:0] pages_log2;
  logic [CW-1:0] phys_count;
  logic [CW-1:0] log_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      pages_log2 <= nbbr_pkg::RST_PAGES_LOG2;
      phys_count <= nbbr_pkg::RST_PHYS_COUNT;
      log_count  <= nbbr_pkg::RST_LOG_COUNT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        nbbr_pkg::REG_PAGES_LOG2: pages_log2 <= cfg_data[LW-1:0];
        nbbr_pkg::REG_PHYS_COUNT: phys_count <= cfg_data;
        nbbr_pkg::REG_LOG_COUNT:  log_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.pages_log2 = (pages_log2 > LOG2_CAP) ? LOG2_CAP : pages_log2;
    cfg.phys_count = (phys_count > CAP) ? CAP : phys_count;
    cfg.log_count  = (log_count > CAP) ? CAP : log_count;
  end

endmodule

// ----- hdl/nbbr_front.sv -----
module nbbr_front #(
  parameter int MAX_BLOCKS = nbbr_pkg::DEF_MAX_BLOCKS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  nbbr_pkg::request_t            request,
  input  nbbr_pkg::cfg_t                cfg,
  output logic                          busy,
  output nbbr_pkg::stage_t              stage,
  output nbbr_pkg::entry_t              entry,
  input  logic                          core_we,
  input  logic [$clog2(MAX_BLOCKS)-1:0] core_waddr,
  input  nbbr_pkg::entry_t              core_wentry,
  output logic                          ram_we,
  output logic [$clog2(MAX_BLOCKS)-1:0] ram_waddr,
  output nbbr_pkg::entry_t              ram_wentry,
  output logic [$clog2(MAX_BLOCKS)-1:0] ram_raddr,
  input  nbbr_pkg::entry_t              ram_rentry
);

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam logic [AW-1:0] LAST = AW'(MAX_BLOCKS - 1);

  logic             clearing;
  logic [AW-1:0]    clr_addr;
  logic             accept;
  logic             fwd_hit;
  nbbr_pkg::entry_t fwd_entry;
  logic [nbbr_pkg::PAGE_W-1:0] page_block;

  assign busy   = clearing;
  assign accept = start && !clearing;

  assign page_block = request.logical_page >> cfg.pages_log2;
  assign ram_raddr  = (request.kind == nbbr_pkg::KIND_TRANSLATE) ?
                      AW'(page_block) : AW'(request.scan_tag);

  // Sweep the map to unmapped after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  always_comb begin
    if (clearing) begin
      ram_we     = 1'b1;
      ram_waddr  = clr_addr;
      ram_wentry = '0;
    end else begin
      ram_we     = core_we;
      ram_waddr  = core_waddr;
      ram_wentry = core_wentry;
    end
  end

  // Hold the request and bypass a write that lands with the read
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else begin
      stage.valid <= accept;
    end
    if (accept) begin
      stage.req <= request;
    end
    fwd_hit   <= core_we && (core_waddr == ram_raddr);
    fwd_entry <= core_wentry;
  end

  assign entry = fwd_hit ? fwd_entry : ram_rentry;

endmodule

// ----- hdl/nbbr_core.sv -----
module nbbr_core #(
  parameter int MAX_BLOCKS = nbbr_pkg::DEF_MAX_BLOCKS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  nbbr_pkg::stage_t              stage,
  input  nbbr_pkg::entry_t              entry,
  input  nbbr_pkg::cfg_t                cfg,
  output logic                          we,
  output logic [$clog2(MAX_BLOCKS)-1:0] waddr,
  output nbbr_pkg::entry_t              wentry,
  output logic                          done,
  output nbbr_pkg::result_t             result
);

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = nbbr_pkg::CNT_W;
  localparam int PW = nbbr_pkg::PAGE_W;
  localparam int TW = nbbr_pkg::TAG_W;

  logic [CW-1:0] phys_pos, phys_pos_next;
  logic [CW-1:0] log_pos, log_pos_next;
  logic [CW-1:0] next_spare, next_spare_next;
  logic          exhausted, exhausted_next;
  logic [CW-1:0] bad_count, bad_count_next;
  logic          closed, closed_next;

  logic [2:0]    status;
  logic [PW-1:0] ppage;
  logic [CW-1:0] pblk;
  logic          complete;
  logic          reached;
  logic [TW-1:0] slot;
  logic [PW-1:0] lb;
  logic [PW-1:0] mask;
  nbbr_pkg::request_t req;

  assign req     = stage.req;
  assign reached = (log_pos >= cfg.log_count) || (phys_pos >= cfg.phys_count);
  assign lb      = req.logical_page >> cfg.pages_log2;
  assign mask    = (PW'(1) << cfg.pages_log2) - PW'(1);

  always_comb begin
    phys_pos_next   = phys_pos;
    log_pos_next    = log_pos;
    next_spare_next = next_spare;
    exhausted_next  = exhausted;
    bad_count_next  = bad_count;
    closed_next     = closed;
    status          = nbbr_pkg::ST_OK;
    ppage           = '0;
    pblk            = '0;
    slot            = '0;
    we              = 1'b0;
    waddr           = '0;
    wentry          = '0;
    if (stage.valid) begin
      unique case (req.kind)
        nbbr_pkg::KIND_SCAN: begin
          if (!closed && reached) begin
            closed_next     = 1'b1;
            next_spare_next = phys_pos;
            exhausted_next  = (phys_pos >= cfg.phys_count);
          end
          if (closed || reached) begin
            status = nbbr_pkg::ST_SCAN_CLOSED;
          end else begin
            case (req.scan_status)
              nbbr_pkg::SCAN_BAD: begin
                if (bad_count != '1) begin
                  bad_count_next = bad_count + CW'(1);
                end
                phys_pos_next = phys_pos + CW'(1);
              end
              nbbr_pkg::SCAN_GOOD: begin
                if (req.scan_tag == nbbr_pkg::BLANK_TAG) begin
                  slot = TW'(log_pos);
                end else if (req.scan_tag >= TW'(cfg.log_count)) begin
                  status = nbbr_pkg::ST_BAD_TAG;
                end else if (entry.mapped) begin
                  status = nbbr_pkg::ST_DUP_TAG;
                end else begin
                  slot = req.scan_tag;
                end
                if (status == nbbr_pkg::ST_OK) begin
                  we            = 1'b1;
                  waddr         = AW'(slot);
                  wentry        = {1'b1, phys_pos};
                  log_pos_next  = log_pos + CW'(1);
                  phys_pos_next = phys_pos + CW'(1);
                end else begin
                  closed_next    = 1'b1;
                  exhausted_next = 1'b1;
                end
              end
              default: begin
                status         = nbbr_pkg::ST_READ_ERROR;
                closed_next    = 1'b1;
                exhausted_next = 1'b1;
              end
            endcase
            if (!closed_next && ((log_pos_next >= cfg.log_count) ||
                                 (phys_pos_next >= cfg.phys_count))) begin
              closed_next     = 1'b1;
              next_spare_next = phys_pos_next;
              exhausted_next  = (phys_pos_next >= cfg.phys_count);
            end
            if (status == nbbr_pkg::ST_OK) begin
              pblk = phys_pos;
            end
          end
        end
        nbbr_pkg::KIND_TRANSLATE: begin
          if ((lb >= PW'(cfg.log_count)) || !entry.mapped) begin
            status = nbbr_pkg::ST_OUT_OF_RANGE;
          end else begin
            pblk  = entry.block;
            ppage = (PW'(entry.block) << cfg.pages_log2) | (req.logical_page & mask);
          end
        end
        nbbr_pkg::KIND_REMAP: begin
          if (CW'(req.logical_block) >= cfg.log_count) begin
            status = nbbr_pkg::ST_OUT_OF_RANGE;
          end else if (!closed || exhausted || (next_spare >= cfg.phys_count)) begin
            status = nbbr_pkg::ST_NO_SPARE;
            if (closed) begin
              exhausted_next = 1'b1;
            end
          end else begin
            pblk            = next_spare;
            we              = 1'b1;
            waddr           = AW'(req.logical_block);
            wentry          = {1'b1, next_spare};
            next_spare_next = next_spare + CW'(1);
            if (next_spare_next >= cfg.phys_count) begin
              exhausted_next = 1'b1;
            end
          end
        end
        default: begin
          status = nbbr_pkg::ST_OUT_OF_RANGE;
        end
      endcase
    end
    complete = (log_pos_next >= cfg.log_count) || (phys_pos_next >= cfg.phys_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phys_pos   <= '0;
      log_pos    <= '0;
      next_spare <= '0;
      exhausted  <= 1'b0;
      bad_count  <= '0;
      closed     <= 1'b0;
      done       <= 1'b0;
    end else begin
      phys_pos   <= phys_pos_next;
      log_pos    <= log_pos_next;
      next_spare <= next_spare_next;
      exhausted  <= exhausted_next;
      bad_count  <= bad_count_next;
      closed     <= closed_next;
      done       <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    result.status          <= status;
    result.physical_page   <= ppage;
    result.physical_block  <= pblk[nbbr_pkg::BLK_W-1:0];
    result.scan_complete   <= complete;
    result.bad_block_count <= bad_count_next;
  end

endmodule

// ----- hdl/nand_bad_block_remapper.sv -----
// Logical-to-physical NAND block map with scan, translate and remap requests.
// Request channel: drive request and raise start; the request is taken at a
// rising edge where start is high and busy is low. One request may be taken
// every cycle.
// Result channel: done is high for exactly one cycle with result valid; the
// receiver cannot hold it off. A taken request is held in the stage register,
// then its result is registered with done; results come in order.
// Each request does one map read and at most one map write; a write that
// meets the next request's read in the same cycle is bypassed, so the rate
// is one request per cycle while busy is low.
// Configuration: cfg_write, cfg_index and cfg_data write one register at a
// rising edge, with no wait; write only while no request is in flight.
// Reset: rst (synchronous) clears the scan state and counters and restores
// the register defaults, then busy stays high while every map entry is
// swept to unmapped. Configuration writes are taken meanwhile.
module nand_bad_block_remapper #(
  parameter int MAX_BLOCKS     = nbbr_pkg::DEF_MAX_BLOCKS,
  parameter int MAX_PAGES_LOG2 = nbbr_pkg::DEF_MAX_PAGES_LOG2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  nbbr_pkg::request_t         request,
  output logic                       done,
  output nbbr_pkg::result_t          result,
  input  logic                       cfg_write,
  input  logic [nbbr_pkg::IDX_W-1:0] cfg_index,
  input  logic [nbbr_pkg::CNT_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int EW = $bits(nbbr_pkg::entry_t);

  nbbr_pkg::cfg_t   cfg;
  nbbr_pkg::stage_t stage;
  nbbr_pkg::entry_t entry;
  logic             core_we;
  logic [AW-1:0]    core_waddr;
  nbbr_pkg::entry_t core_wentry;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  nbbr_pkg::entry_t ram_wentry;
  logic [AW-1:0]    ram_raddr;
  nbbr_pkg::entry_t ram_rentry;

  nbbr_cfg #(
    .MAX_BLOCKS     (MAX_BLOCKS),
    .MAX_PAGES_LOG2 (MAX_PAGES_LOG2)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  nbbr_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_BLOCKS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .raddr (ram_raddr),
    .rdata (ram_rentry)
  );

  nbbr_front #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .request     (request),
    .cfg         (cfg),
    .busy        (busy),
    .stage       (stage),
    .entry       (entry),
    .core_we     (core_we),
    .core_waddr  (core_waddr),
    .core_wentry (core_wentry),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wentry  (ram_wentry),
    .ram_raddr   (ram_raddr),
    .ram_rentry  (ram_rentry)
  );

  nbbr_core #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .stage  (stage),
    .entry  (entry),
    .cfg    (cfg),
    .we     (core_we),
    .waddr  (core_waddr),
    .wentry (core_wentry),
    .done   (done),
    .result (result)
  );

endmodule

// ----- hdl/nbbr_checker.sv -----
`include "assert_macros.svh"

module nbbr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input nbbr_pkg::result_t          result
);

  logic taken;

  assign taken = start && !busy;

  `NBBR_ASSERT_ALWAYS(a_sweep_after_reset, clk, rst |=> busy, "no map sweep after reset")
  `NBBR_ASSERT(a_result_follows, clk, rst, taken |-> ##2 done, "request gave no result")
  `NBBR_ASSERT(a_no_stray_result, clk, rst, done |-> $past(taken, 2), "result without request")
  `NBBR_ASSERT(a_error_zeroes, clk, rst, (done && result.status != nbbr_pkg::ST_OK) |-> (result.physical_page == '0 && result.physical_block == '0), "error result carries an address")
  `NBBR_ASSERT(a_bad_count_rises, clk, rst, (done && $past(done)) |-> (result.bad_block_count >= $past(result.bad_block_count)), "bad block count fell")

endmodule

bind nand_bad_block_remapper nbbr_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .result    (result)
);

// ----- verif/nand_bad_block_remapper_test.sv -----
module nand_bad_block_remapper_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nbbr_pkg::*;

  localparam int unsigned MAP_DEPTH     = DEF_MAX_BLOCKS;
  localparam int unsigned LOG2_CAP      = DEF_MAX_PAGES_LOG2;
  localparam int unsigned BAD_COUNT_CAP = 8191;

  localparam logic [1:0] KIND_UNKNOWN   = 2'd3;
  localparam logic [1:0] SCAN_READ_ERR  = 2'd2;
  localparam logic [1:0] SCAN_OTHER_ERR = 2'd3;

  typedef enum int {
    END_BY_COUNT,
    END_BY_LOWERED_COUNT,
    END_BY_BAD_TAG,
    END_BY_DUP_TAG,
    END_BY_READ_ERROR
  } scan_end_e;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             start     = 1'b0;
  logic             busy;
  request_t         request   = '0;
  logic             done;
  result_t          result;
  logic             cfg_write = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0] cfg_data  = '0;

  cfg_t             model_cfg = {RST_PAGES_LOG2, RST_PHYS_COUNT, RST_LOG_COUNT};
  logic [CNT_W-1:0] mapped_block [MAP_DEPTH];
  bit               mapped [MAP_DEPTH];
  int unsigned      scan_phys_pos = 0;
  int unsigned      scan_log_pos  = 0;
  int unsigned      next_spare    = 0;
  int unsigned      bad_seen      = 0;
  bit               scan_closed   = 1'b0;
  bit               spares_gone   = 1'b0;

  bit               gen_claimed [MAP_DEPTH];
  int unsigned      gen_phys = 0;
  int unsigned      gen_log  = 0;
  int unsigned      known_slots[$];

  request_t         queued_requests[$];
  result_t          awaited_results[$];
  int unsigned      fail_count = 0;
  int unsigned      burst_left = 1;
  int unsigned      gap_left   = 0;

  nand_bad_block_remapper i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial forever #6 clk = ~clk;

  function automatic int unsigned capped_count(logic [CNT_W-1:0] count);
    return (count > MAP_DEPTH) ? MAP_DEPTH : count;
  endfunction

  function automatic int unsigned page_shift();
    return (model_cfg.pages_log2 > LOG2_CAP) ? LOG2_CAP : model_cfg.pages_log2;
  endfunction

  function automatic bit scan_at_limit();
    return scan_log_pos >= capped_count(model_cfg.log_count) ||
           scan_phys_pos >= capped_count(model_cfg.phys_count);
  endfunction

  function automatic void close_scan_at_limit();
    if (!scan_closed && scan_at_limit()) begin
      scan_closed = 1'b1;
      next_spare  = scan_phys_pos;
      spares_gone = scan_phys_pos >= capped_count(model_cfg.phys_count);
    end
  endfunction

  function automatic result_t block_map_response(request_t r);
    result_t     res;
    int unsigned lbc;
    int unsigned pbc;
    int unsigned shift;
    int unsigned slot;
    int unsigned lblk;
    logic [31:0] page;
    res   = '0;
    slot  = 0;
    lbc   = capped_count(model_cfg.log_count);
    pbc   = capped_count(model_cfg.phys_count);
    shift = page_shift();
    res.status = ST_OK;
    case (r.kind)
      KIND_SCAN: begin
        close_scan_at_limit();
        if (scan_closed) begin
          res.status = ST_SCAN_CLOSED;
        end else begin
          res.physical_block = BLK_W'(scan_phys_pos);
          if (r.scan_status == SCAN_BAD) begin
            if (bad_seen < BAD_COUNT_CAP) bad_seen++;
            scan_phys_pos++;
          end else if (r.scan_status == SCAN_GOOD) begin
            if (r.scan_tag == BLANK_TAG) begin
              slot = scan_log_pos;
            end else if (r.scan_tag >= lbc) begin
              res.status = ST_BAD_TAG;
            end else if (mapped[r.scan_tag]) begin
              res.status = ST_DUP_TAG;
            end else begin
              slot = r.scan_tag;
            end
            if (res.status == ST_OK && slot < MAP_DEPTH) begin
              mapped_block[slot] = CNT_W'(scan_phys_pos);
              mapped[slot]       = 1'b1;
              scan_log_pos++;
              scan_phys_pos++;
            end else begin
              scan_closed = 1'b1;
              spares_gone = 1'b1;
            end
          end else begin
            res.status  = ST_READ_ERROR;
            scan_closed = 1'b1;
            spares_gone = 1'b1;
          end
          if (res.status != ST_OK) res.physical_block = '0;
          close_scan_at_limit();
        end
      end
      KIND_TRANSLATE: begin
        lblk = r.logical_page >> shift;
        if (lblk >= lbc || !mapped[lblk]) begin
          res.status = ST_OUT_OF_RANGE;
        end else begin
          page = (32'(mapped_block[lblk]) << shift) |
                 (32'(r.logical_page) & ((32'd1 << shift) - 32'd1));
          res.physical_page  = page[PAGE_W-1:0];
          res.physical_block = mapped_block[lblk][BLK_W-1:0];
        end
      end
      KIND_REMAP: begin
        if (r.logical_block >= lbc) begin
          res.status = ST_OUT_OF_RANGE;
        end else if (!scan_closed || spares_gone || next_spare >= pbc) begin
          res.status = ST_NO_SPARE;
          if (scan_closed) spares_gone = 1'b1;
        end else begin
          res.physical_block            = BLK_W'(next_spare);
          mapped_block[r.logical_block] = CNT_W'(next_spare);
          mapped[r.logical_block]       = 1'b1;
          next_spare++;
          if (next_spare >= pbc) spares_gone = 1'b1;
        end
      end
      default: res.status = ST_OUT_OF_RANGE;
    endcase
    res.scan_complete   = scan_at_limit();
    res.bad_block_count = CNT_W'(bad_seen);
    return res;
  endfunction

  function automatic request_t random_request();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(request_t)-1:0];
  endfunction

  function automatic void queue_item(logic [1:0] kind, logic [PAGE_W-1:0] page,
                                     logic [BLK_W-1:0] blk);
    request_t r;
    r               = random_request();
    r.kind          = kind;
    r.logical_page  = page;
    r.logical_block = blk;
    queued_requests.push_back(r);
  endfunction

  function automatic void queue_scan(logic [1:0] read_state, logic [TAG_W-1:0] tag);
    request_t    r;
    int unsigned slot;
    r             = random_request();
    r.kind        = KIND_SCAN;
    r.scan_status = read_state;
    r.scan_tag    = tag;
    queued_requests.push_back(r);
    slot = (tag == BLANK_TAG) ? gen_log : tag;
    if (read_state == SCAN_BAD) begin
      gen_phys++;
    end else if (read_state == SCAN_GOOD && slot < MAP_DEPTH) begin
      gen_claimed[slot] = 1'b1;
      known_slots.push_back(slot);
      gen_log++;
      gen_phys++;
    end
  endfunction

  function automatic void queue_mixed_item();
    int unsigned      pick;
    int unsigned      lbc;
    int unsigned      blk;
    logic [PAGE_W-1:0] page;
    lbc  = capped_count(model_cfg.log_count);
    pick = $urandom_range(0, 99);
    page = PAGE_W'($urandom);
    if (known_slots.size() != 0 && $urandom_range(0, 9) < 6)
      blk = known_slots[$urandom_range(0, known_slots.size() - 1)];
    else
      blk = (lbc != 0) ? $urandom_range(0, lbc - 1) : 0;
    if (pick < 45) begin
      if (pick >= 5)
        page = PAGE_W'((blk << page_shift()) | (page & ((32'd1 << page_shift()) - 1)));
      queue_item(KIND_TRANSLATE, page, BLK_W'($urandom));
    end else if (pick < 80) begin
      if (pick >= 75) blk = $urandom_range(0, (1 << BLK_W) - 1);
      else known_slots.push_back(blk);
      queue_item(KIND_REMAP, page, BLK_W'(blk));
    end else if (pick < 90) begin
      queue_item(KIND_SCAN, page, BLK_W'($urandom));
    end else begin
      queue_item(KIND_UNKNOWN, page, BLK_W'($urandom));
    end
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (queued_requests.size() != 0 || start || awaited_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CNT_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_PAGES_LOG2: model_cfg.pages_log2 = data[LOG2_W-1:0];
      REG_PHYS_COUNT: model_cfg.phys_count = data;
      REG_LOG_COUNT:  model_cfg.log_count  = data;
      default: ;
    endcase
  endtask

  task automatic configure(int unsigned log2, int unsigned phys, int unsigned logi);
    wait_idle();
    write_reg(REG_PAGES_LOG2, CNT_W'(log2));
    write_reg(REG_PHYS_COUNT, CNT_W'(phys));
    write_reg(REG_LOG_COUNT, CNT_W'(logi));
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) awaited_results.push_back(block_map_response(request));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (queued_requests.size() != 0) begin
          request <= queued_requests.pop_front();
          start   <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result with no request outstanding, expected none, actual %p",
                 $time, result);
        fail_count++;
      end else begin
        result_t want;
        want = awaited_results.pop_front();
        compare_field("status", want.status, result.status);
        compare_field("physical_page", want.physical_page, result.physical_page);
        compare_field("physical_block", want.physical_block, result.physical_block);
        compare_field("scan_complete", want.scan_complete, result.scan_complete);
        compare_field("bad_block_count", want.bad_block_count, result.bad_block_count);
      end
    end
  end

  initial begin
    scan_end_e        scan_end;
    int unsigned      pick;
    int unsigned      stop_at;
    int unsigned      lbc;
    int unsigned      pbc;
    int unsigned      slot;
    logic [TAG_W-1:0] tag;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    lbc = $urandom_range(5, 60);
    pbc = lbc + $urandom_range(0, 40);
    configure($urandom_range(1, 8), pbc, lbc);

    queue_item(KIND_UNKNOWN, PAGE_W'($urandom), BLK_W'($urandom));
    queue_item(KIND_TRANSLATE, '0, BLK_W'($urandom));
    queue_item(KIND_TRANSLATE, '1, BLK_W'($urandom));
    queue_item(KIND_REMAP, PAGE_W'($urandom), '0);
    queue_item(KIND_REMAP, PAGE_W'($urandom), '1);
    queue_scan(SCAN_BAD, TAG_W'($urandom));
    queue_scan(SCAN_GOOD, BLANK_TAG);
    queue_scan(SCAN_GOOD, TAG_W'(2));
    // blank tag lands on the slot just claimed by tag 2
    queue_scan(SCAN_GOOD, BLANK_TAG);
    queue_item(KIND_TRANSLATE, PAGE_W'($urandom_range(0, (1 << page_shift()) - 1)), '0);
    queue_item(KIND_TRANSLATE,
               PAGE_W'((2 << page_shift()) | $urandom_range(0, (1 << page_shift()) - 1)),
               '1);

    pick     = $urandom_range(0, 7);
    scan_end = (pick < 4) ? END_BY_COUNT : scan_end_e'(pick - 3);
    stop_at  = $urandom_range(6, 60);
    while (gen_phys < pbc && gen_log < lbc) begin
      if (scan_end != END_BY_COUNT && gen_phys >= stop_at) break;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        queue_item(KIND_TRANSLATE, PAGE_W'($urandom), BLK_W'($urandom));
      end else if (pick < 12) begin
        queue_item(KIND_REMAP, PAGE_W'($urandom), BLK_W'($urandom));
      end else if (pick < 30) begin
        queue_scan(SCAN_BAD, TAG_W'($urandom));
      end else begin
        tag = BLANK_TAG;
        if (pick >= 60) begin
          repeat (8) begin
            slot = $urandom_range(0, lbc - 1);
            if (tag == BLANK_TAG && !gen_claimed[slot]) tag = TAG_W'(slot);
          end
        end
        queue_scan(SCAN_GOOD, tag);
      end
    end

    case (scan_end)
      END_BY_LOWERED_COUNT: begin
        if ($urandom_range(0, 1))
          configure(model_cfg.pages_log2, model_cfg.phys_count, $urandom_range(0, gen_log));
        else
          configure(model_cfg.pages_log2, $urandom_range(0, gen_phys), model_cfg.log_count);
        // the scan has not yet seen its count lowered
        queue_item(KIND_REMAP, PAGE_W'($urandom), '0);
      end
      END_BY_BAD_TAG: queue_scan(SCAN_GOOD, TAG_W'($urandom_range(lbc, BLANK_TAG - 1)));
      END_BY_DUP_TAG:
        queue_scan(SCAN_GOOD, TAG_W'(known_slots[$urandom_range(0, known_slots.size() - 1)]));
      END_BY_READ_ERROR:
        queue_scan($urandom_range(0, 1) ? SCAN_READ_ERR : SCAN_OTHER_ERR, TAG_W'($urandom));
      default: ;
    endcase
    repeat (3) queue_item(KIND_SCAN, PAGE_W'($urandom), BLK_W'($urandom));

    configure(0, 4096, $urandom_range(100, 4096));
    repeat (200) queue_mixed_item();
    configure(15, 8191, 8191);
    repeat (200) queue_mixed_item();
    configure(8, 4096, $urandom_range(1, 200));
    repeat (200) queue_mixed_item();
    wait_idle();
    configure($urandom_range(1, 7), next_spare + $urandom_range(0, 40), 4096);
    repeat (200) queue_mixed_item();
    configure($urandom_range(0, 15), 0, 0);
    repeat (25) queue_mixed_item();
    configure($urandom_range(0, 15), 1, 1);
    repeat (25) queue_mixed_item();

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
